// ===== sv/light_pulse_symbol_receiver_unit_defines.svh =====
// Assertion macros shared by the receiver RTL.
`ifndef LIGHT_PULSE_SYMBOL_RECEIVER_UNIT_DEFINES_SVH
`define LIGHT_PULSE_SYMBOL_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPSR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPSR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lpsr_pkg.sv =====
// Package with shared types and constants of the light pulse symbol receiver.
`default_nettype none

package lpsr_pkg;

    localparam int LEVEL_W = 16;
    localparam int SYM_W   = 4;
    localparam int DIGIT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PAT   = 2'd2;

    // Register reset values
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 16'd75;
    localparam logic [SYM_W-1:0]   START_PAT_RST = 4'b1110;
    localparam logic [SYM_W-1:0]   END_PAT_RST   = 4'b1100;

    // Symbol code that carries digit zero
    localparam logic [SYM_W-1:0] CODE_DIGIT_ZERO = 4'b1010;
    localparam logic [SYM_W-1:0] CODE_DIGIT_MIN  = 4'd1;
    localparam logic [SYM_W-1:0] CODE_DIGIT_MAX  = 4'd9;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_START = 2'd1,
        EVT_END   = 2'd2,
        EVT_DIGIT = 2'd3
    } evt_t;

    // One recovered bit, when done is set
    typedef struct packed {
        logic done;
        logic value;
    } bit_evt_t;

    // Symbol decoder result
    typedef struct packed {
        evt_t               evt;
        logic [DIGIT_W-1:0] digit;
    } sym_res_t;

endpackage

`default_nettype wire

// ===== sv/light_pulse_symbol_receiver_unit.sv =====
// Top level of the light pulse symbol receiver.
//
// Input channel (s_valid/s_ready/s_light_level): one light sample per transfer.
// Result channel (m_*): exactly one result per sample: the sliced level, a flag
// and value for a recovered bit, a frame event and a decoded digit.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 threshold, 1 start pattern, 2 end pattern); write only while idle.
// From input transfer to m_valid: the sample is held in an input register,
// sliced and decoded in one combinational pass (threshold compare, run
// tracker, symbol decoder), and caught in the result register.
// Throughput: one sample per cycle while results are taken; the input register
// refills in the same cycle that its sample moves to the result register.
// Stall: when m_ready is low the result holds, the input register keeps one
// more sample, and then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): both registers empty, run and symbol
// state cleared, frame idle, configuration back to 75 / 1110 / 1100.
`default_nettype none
`include "light_pulse_symbol_receiver_unit_defines.svh"

module light_pulse_symbol_receiver_unit #(
    parameter int SAMPLES_PER_BIT = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_light_level,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_sliced_bit,
    output logic             m_bit_done,
    output logic             m_recovered_bit,
    output logic [1:0]       m_event_res,
    output logic [3:0]       m_digit,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import lpsr_pkg::*;

    logic [LEVEL_W-1:0] threshold_reg;
    logic [SYM_W-1:0]   start_pat_reg;
    logic [SYM_W-1:0]   end_pat_reg;

    logic               in_valid_reg;
    logic [LEVEL_W-1:0] in_level_reg;
    logic               advance;
    logic               sliced;
    bit_evt_t           bit_evt;
    sym_res_t           sym_res;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            start_pat_reg <= START_PAT_RST;
            end_pat_reg   <= END_PAT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_START_PAT: start_pat_reg <= cfg_data[SYM_W-1:0];
                CFG_END_PAT:   end_pat_reg   <= cfg_data[SYM_W-1:0];
                default: ;
            endcase
        end
    end

    // Move the held sample on when the result register is free or being drained.
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_light_level;
        end
    end

    // Slice: strictly above the threshold is light on.
    assign sliced = in_level_reg > threshold_reg;

    lpsr_run #(
        .SAMPLES_PER_BIT(SAMPLES_PER_BIT)
    ) u_run (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .sliced  (sliced),
        .bit_evt (bit_evt)
    );

    lpsr_symbol u_symbol (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .bit_evt   (bit_evt),
        .start_pat (start_pat_reg),
        .end_pat   (end_pat_reg),
        .res       (sym_res)
    );

    // Result register: valid drops once taken unless a new sample moves in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_sliced_bit    <= sliced;
            m_bit_done      <= bit_evt.done;
            m_recovered_bit <= bit_evt.value;
            m_event_res     <= sym_res.evt;
            m_digit         <= sym_res.digit;
        end
    end

    // A frame event can only come from a symbol that a recovered bit completed.
    `LPSR_ASSERT_IMPL(a_event_needs_bit, aclk, aresetn, m_valid && (m_event_res != EVT_NONE),
                      m_bit_done, "frame event without a recovered bit")
    // The digit field is zero unless a digit was received, and never above nine.
    `LPSR_ASSERT_IMPL(a_digit_range, aclk, aresetn, m_valid,
                      ((m_event_res == EVT_DIGIT) && (m_digit <= CODE_DIGIT_MAX))
                      || (m_digit == '0), "digit field out of range")
    // No recovered value without the done flag.
    `LPSR_ASSERT_IMPL(a_bit_value, aclk, aresetn, m_valid && !m_bit_done,
                      !m_recovered_bit, "recovered bit set without done")
    // A held sample that cannot move on stays in the input register.
    `LPSR_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance,
                      in_valid_reg && $stable(in_level_reg), "held sample lost")

endmodule

`default_nettype wire

// ===== sv/lpsr_run.sv =====
// Run-length tracker that turns sliced samples into recovered bits.
`default_nettype none

module lpsr_run #(
    parameter int SAMPLES_PER_BIT = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic              sliced,
    output lpsr_pkg::bit_evt_t     bit_evt
);
    import lpsr_pkg::*;

    localparam int RL_W = $clog2(SAMPLES_PER_BIT);
    localparam logic [RL_W-1:0] LEN_ONE  = RL_W'(1);
    localparam logic [RL_W-1:0] LEN_LAST = RL_W'(SAMPLES_PER_BIT - 1);

    logic            level_reg, level_next;
    logic [RL_W-1:0] len_reg, len_next;

    always_comb begin
        level_next    = level_reg;
        len_next      = len_reg;
        bit_evt.done  = 1'b0;
        bit_evt.value = 1'b0;
        if (len_reg == '0) begin
            // empty run: open a new one at this level
            level_next = sliced;
            len_next   = LEN_ONE;
        end else if (sliced != level_reg) begin
            // level change; a run one short of full still yields its bit
            if (len_reg == LEN_LAST) begin
                bit_evt.done  = 1'b1;
                bit_evt.value = level_reg;
            end
            level_next = sliced;
            len_next   = LEN_ONE;
        end else if (len_reg == LEN_LAST) begin
            bit_evt.done  = 1'b1;
            bit_evt.value = sliced;
            len_next      = '0;
        end else begin
            len_next = len_reg + LEN_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            len_reg   <= '0;
        end else if (advance) begin
            level_reg <= level_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lpsr_symbol.sv =====
// Symbol assembler and frame decoder for recovered bits.
`default_nettype none

module lpsr_symbol (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire lpsr_pkg::bit_evt_t         bit_evt,
    input  wire logic [lpsr_pkg::SYM_W-1:0] start_pat,
    input  wire logic [lpsr_pkg::SYM_W-1:0] end_pat,
    output lpsr_pkg::sym_res_t              res
);
    import lpsr_pkg::*;

    logic [SYM_W-1:0] bits_reg, bits_next;
    logic [1:0]       fill_reg, fill_next;
    logic             open_reg, open_next;
    logic [SYM_W-1:0] code;
    logic [1:0]       pos;

    always_comb begin
        bits_next = bits_reg;
        fill_next = fill_reg;
        open_next = open_reg;
        res.evt   = EVT_NONE;
        res.digit = '0;
        // first bit lands at the top
        pos       = 2'd3 - fill_reg;
        code      = bits_reg;
        code[pos] = bit_evt.value;
        if (bit_evt.done) begin
            bits_next = code;
            if (fill_reg == 2'd3) begin
                fill_next = 2'd0;
                if (!open_reg) begin
                    if (code == start_pat) begin
                        open_next = 1'b1;
                        res.evt   = EVT_START;
                    end else begin
                        // slide: keep the last three bits and wait for one more
                        bits_next = {code[SYM_W-2:0], 1'b0};
                        fill_next = 2'd3;
                    end
                end else if (code == end_pat) begin
                    open_next = 1'b0;
                    res.evt   = EVT_END;
                end else if (code == CODE_DIGIT_ZERO) begin
                    res.evt = EVT_DIGIT;
                end else if (code >= CODE_DIGIT_MIN && code <= CODE_DIGIT_MAX) begin
                    res.evt   = EVT_DIGIT;
                    res.digit = code;
                end
            end else begin
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= '0;
            fill_reg <= '0;
            open_reg <= 1'b0;
        end else if (advance) begin
            bits_reg <= bits_next;
            fill_reg <= fill_next;
            open_reg <= open_next;
        end
    end

endmodule

`default_nettype wire
